### design/assert_macros.svh
// Assertion macros shared by the deframer modules.
// Every macro expects signals named clk and rst in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/h4dfr_pkg.sv
// Types, codes and constants of the H:4 packet deframer.
// No dependencies; used by every deframer module.
package h4dfr_pkg;

  localparam logic [7:0] TYPE_ACL = 8'h02;
  localparam logic [7:0] TYPE_EVT = 8'h04;
  localparam logic [7:0] TYPE_ISO = 8'h05;

  localparam logic [15:0] ISO_LEN_MASK = 16'h3FFF;

  localparam logic [1:0] KIND_EVT = 2'd0;
  localparam logic [1:0] KIND_ACL = 2'd1;
  localparam logic [1:0] KIND_ISO = 2'd2;

  localparam logic [1:0] STAT_BYTE    = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_NOBUF   = 2'd2;

  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = 3;
  localparam int HDR_IDX_W = 2;

  localparam logic [RES_CNT_W-1:0] HDR_LEN_EVT  = 3'd2;
  localparam logic [RES_CNT_W-1:0] HDR_LEN_LONG = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVT  = 4'b0010,
    ST_ACL  = 4'b0100,
    ST_ISO  = 4'b1000
  } kind_state_t;

  typedef logic [RES_CNT_W-1:0] res_cnt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] packet_kind;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_vec_t;

  // Handoff from the parser to the result buffer.
  typedef struct packed {
    logic     load;
    res_cnt_t cnt;
  } emit_t;

  function automatic logic [1:0] kind_code(kind_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_ACL:  code = KIND_ACL;
      ST_ISO:  code = KIND_ISO;
      default: code = KIND_EVT;
    endcase
    return code;
  endfunction

endpackage

### design/h4dfr_parse.sv
// Packet parser: framing state, header capture and result generation.
// Depends on h4dfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module h4dfr_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic              buffer_granted,
  output h4dfr_pkg::emit_t  emit,
  output h4dfr_pkg::res_vec_t results
);
  import h4dfr_pkg::*;

  kind_state_t state, state_next, kind_eff;
  logic        header_done, header_done_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  hdr_store [MAX_RES];

  logic [RES_CNT_W-1:0] hlen, left3, left_new, hdr_pos;
  logic [HDR_IDX_W-1:0] idx;
  logic                 left_ok, hdr_wr;
  logic [7:0]           hdr_cur [MAX_RES];
  logic [15:0]          plen, bl_dec;
  logic [1:0]           kcode;
  res_cnt_t             cnt;

  always_comb begin
    // A stale payload phase with nothing left falls back to idle.
    kind_eff         = state;
    state_next       = state;
    header_done_next = header_done;
    bytes_left_next  = bytes_left;
    if (state != ST_IDLE && header_done && bytes_left == 16'd0) begin
      kind_eff         = ST_IDLE;
      state_next       = ST_IDLE;
      header_done_next = 1'b0;
      bytes_left_next  = 16'd0;
    end

    hlen     = (state == ST_EVT) ? HDR_LEN_EVT : HDR_LEN_LONG;
    left_ok  = (bytes_left != 16'd0) && (bytes_left <= {13'd0, hlen});
    left3    = left_ok ? bytes_left[RES_CNT_W-1:0] : hlen;
    hdr_pos  = hlen - left3;
    idx      = hdr_pos[HDR_IDX_W-1:0];
    left_new = left3 - 3'd1;
    bl_dec   = bytes_left - 16'd1;
    kcode    = kind_code(state);

    for (int i = 0; i < MAX_RES; i++) begin
      hdr_cur[i] = (HDR_IDX_W'(i) == idx) ? rx_byte : hdr_store[i];
    end

    unique case (state)
      ST_ACL:  plen = {hdr_cur[3], hdr_cur[2]};
      ST_ISO:  plen = {hdr_cur[3], hdr_cur[2]} & ISO_LEN_MASK;
      default: plen = {8'd0, hdr_cur[1]};
    endcase

    hdr_wr  = 1'b0;
    cnt     = '0;
    results = '0;

    unique case (kind_eff) inside
      ST_EVT, ST_ACL, ST_ISO: begin
        if (!header_done) begin
          hdr_wr          = 1'b1;
          bytes_left_next = {13'd0, left_new};
          if (left_new == 3'd0) begin
            if (!buffer_granted) begin
              cnt                    = res_cnt_t'(1);
              results[0].packet_kind = kcode;
              results[0].status      = STAT_NOBUF;
              state_next             = ST_IDLE;
              header_done_next       = 1'b0;
              bytes_left_next        = 16'd0;
            end else begin
              cnt = hlen;
              for (int i = 0; i < MAX_RES; i++) begin
                results[i].out_byte    = hdr_cur[i];
                results[i].packet_kind = kcode;
                results[i].status      = STAT_BYTE;
                results[i].last        = (plen == 16'd0) && (RES_CNT_W'(i + 1) == hlen);
              end
              if (plen == 16'd0) begin
                state_next       = ST_IDLE;
                header_done_next = 1'b0;
                bytes_left_next  = 16'd0;
              end else begin
                header_done_next = 1'b1;
                bytes_left_next  = plen;
              end
            end
          end
        end else begin
          // Payload byte: pass through, mark the final one.
          cnt                    = res_cnt_t'(1);
          results[0].out_byte    = rx_byte;
          results[0].packet_kind = kcode;
          results[0].status      = STAT_BYTE;
          results[0].last        = (bl_dec == 16'd0);
          bytes_left_next        = bl_dec;
          if (bl_dec == 16'd0) begin
            state_next       = ST_IDLE;
            header_done_next = 1'b0;
          end
        end
      end
      default: begin
        header_done_next = 1'b0;
        unique case (rx_byte)
          TYPE_EVT: begin
            state_next      = ST_EVT;
            bytes_left_next = {13'd0, HDR_LEN_EVT};
          end
          TYPE_ACL: begin
            state_next      = ST_ACL;
            bytes_left_next = {13'd0, HDR_LEN_LONG};
          end
          TYPE_ISO: begin
            state_next      = ST_ISO;
            bytes_left_next = {13'd0, HDR_LEN_LONG};
          end
          default: begin
            cnt                    = res_cnt_t'(1);
            results[0].out_byte    = rx_byte;
            results[0].packet_kind = KIND_EVT;
            results[0].status      = STAT_UNKNOWN;
          end
        endcase
      end
    endcase
  end

  assign emit.load = step;
  assign emit.cnt  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      header_done <= 1'b0;
      bytes_left  <= 16'd0;
    end else if (step) begin
      state       <= state_next;
      header_done <= header_done_next;
      bytes_left  <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_wr) begin
      hdr_store[idx] <= rx_byte;
    end
  end

  `ASSERT_ALWAYS(a_payload_has_count, !header_done || bytes_left != 16'd0)
  `ASSERT_NEXT(a_nobuf_goes_idle, step && cnt == res_cnt_t'(1) && results[0].status == STAT_NOBUF, state == ST_IDLE)

endmodule

### design/h4dfr_outq.sv
// Result buffer: holds up to four results of one item and drains one per cycle while ready is high.
// Depends on h4dfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module h4dfr_outq (
  input  logic                clk,
  input  logic                rst,
  input  h4dfr_pkg::emit_t    emit,
  input  h4dfr_pkg::res_vec_t results,
  input  logic                ready,
  output logic                valid,
  output h4dfr_pkg::res_t     head,
  output logic                can_load
);
  import h4dfr_pkg::*;

  res_vec_t entries;
  res_cnt_t count;
  logic     pop;

  assign valid    = (count != '0);
  assign pop      = valid && ready;
  assign can_load = (count == '0) || (count == res_cnt_t'(1) && pop);
  assign head     = entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (emit.load) begin
      count <= emit.cnt;
    end else if (pop) begin
      count <= count - res_cnt_t'(1);
    end
  end

  // Load a fresh batch, or advance the queue by one.
  always_ff @(posedge clk) begin
    if (emit.load) begin
      entries <= results;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        entries[i] <= entries[i + 1];
      end
      entries[MAX_RES-1] <= '0;
    end
  end

  `ASSERT_IMPLY(a_load_only_when_drained, emit.load, can_load)
  `ASSERT_ALWAYS(a_count_bounded, count <= res_cnt_t'(MAX_RES))

endmodule

### design/hci_h4_packet_deframer_unit.sv
// HCI H:4 packet deframer, top level.
// Depends on h4dfr_pkg, h4dfr_parse and h4dfr_outq.
//
// Takes one byte received from the HCI UART per word and splits the stream
// into H:4 packets. In idle a byte is the packet type: event (0x04, 2-byte
// header), ACL (0x02, 4-byte header) or ISO (0x05, 4-byte header); any other
// byte comes back at once with status 1 and is dropped. Header bytes are held
// until the header is complete; buffer_granted is sampled on that byte. With
// a grant, all header bytes come out in order, followed by one word per
// payload byte, with last set on the final byte of the packet (on the final
// header byte when the payload length is zero). Without a grant, one word
// with status 2 reports the dropped packet and the block returns to idle.
// A byte enters an input register and is parsed from there into a four-entry
// result buffer, which holds the results in registers and offers them in order.
// A byte is parsed only when the buffer is empty or is giving up its final
// word, so with a ready receiver bytes that give at most one result flow at
// one word per cycle. A byte that completes a granted header gives 2 (event)
// or 4 (ACL, ISO) results; the buffer drains one word per cycle while the
// receiver is ready, so the next byte waits in the input register until the
// last of them is taken. While results wait, the input register takes one
// more byte and then holds item_ready low.
module hci_h4_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] rx_byte,
  input  logic       buffer_granted,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic [1:0] packet_kind,
  output logic [1:0] status,
  output logic       last
);
  import h4dfr_pkg::*;

  logic       in_full;
  logic [7:0] rx_q;
  logic       grant_q;
  logic       advance;
  logic       can_load;
  emit_t      emit;
  res_vec_t   results;
  res_t       head;

  // Parse the held byte once the result buffer can take its whole batch.
  assign advance    = in_full && can_load;
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Hold the input word until it is parsed.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      rx_q    <= rx_byte;
      grant_q <= buffer_granted;
    end
  end

  h4dfr_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .rx_byte        (rx_q),
    .buffer_granted (grant_q),
    .emit           (emit),
    .results        (results)
  );

  h4dfr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .results  (results),
    .ready    (result_ready),
    .valid    (result_valid),
    .head     (head),
    .can_load (can_load)
  );

  assign out_byte    = head.out_byte;
  assign packet_kind = head.packet_kind;
  assign status      = head.status;
  assign last        = head.last;

endmodule

### verif/testbench.sv
// Self-checking testbench for the HCI H:4 packet deframer (hci_h4_packet_deframer_unit).
// Depends on h4dfr_pkg for the type bytes, packet kinds, status codes and result word.
// Feeds directed and random H:4 byte streams and checks every result word.
module testbench;
  import h4dfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 60;   // bytes taken before the long receiver hold-off
  localparam int HOLD_LEN    = 300;  // cycles of that hold-off
  localparam int DRAIN_PAUSE = 20;   // extra cycles after the last expected word

  typedef enum logic [1:0] {
    PK_IDLE,
    PK_EVT,
    PK_ACL,
    PK_ISO
  } parse_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       grant;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       buffer_granted = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] packet_kind;
  logic [1:0] status;
  logic       last;

  rx_item_t rx_q[$];
  res_t     frame_q[$];
  rx_item_t next_item;

  // Predictor state
  parse_kind_t st_kind = PK_IDLE;
  logic [1:0]  st_code = KIND_EVT;
  logic        st_hdr_done = 1'b0;
  logic [15:0] st_left = '0;
  logic [7:0]  hdr_bytes [4];

  int bytes_taken = 0;
  int words_seen  = 0;
  int err_cnt     = 0;
  int cycle_cnt   = 0;
  int send_gap    = 0;
  bit send_calm   = 1'b0;
  int recv_stall  = 0;
  bit recv_calm   = 1'b0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  hci_h4_packet_deframer_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .rx_byte        (rx_byte),
    .buffer_granted (buffer_granted),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .packet_kind    (packet_kind),
    .status         (status),
    .last           (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR word %0d: %0s got %0d, expected %0d", words_seen, what, got, want);
    err_cnt++;
  endtask

  task automatic add_word(input logic [7:0] b, input logic [1:0] kind,
                          input logic [1:0] stat, input logic lst);
    res_t w;
    w.out_byte    = b;
    w.packet_kind = kind;
    w.status      = stat;
    w.last        = lst;
    frame_q.push_back(w);
  endtask

  task automatic go_idle();
    st_kind     = PK_IDLE;
    st_hdr_done = 1'b0;
    st_left     = '0;
  endtask

  // Advance the deframer state by one accepted byte and queue the words it yields.
  task automatic deframe_byte(input logic [7:0] b, input logic grant);
    int          hlen;
    logic [15:0] plen;
    if (st_kind != PK_IDLE && st_hdr_done && st_left == 0) go_idle();

    if (st_kind == PK_IDLE) begin
      st_hdr_done = 1'b0;
      case (b)
        TYPE_EVT: begin
          st_kind = PK_EVT; st_code = KIND_EVT; st_left = 16'd2;
        end
        TYPE_ACL: begin
          st_kind = PK_ACL; st_code = KIND_ACL; st_left = 16'd4;
        end
        TYPE_ISO: begin
          st_kind = PK_ISO; st_code = KIND_ISO; st_left = 16'd4;
        end
        default: add_word(b, KIND_EVT, STAT_UNKNOWN, 1'b0);
      endcase
    end else if (!st_hdr_done) begin
      hlen = (st_kind == PK_EVT) ? 2 : 4;
      hdr_bytes[hlen - int'(st_left)] = b;
      st_left = st_left - 16'd1;
      if (st_left == 0) begin
        case (st_kind)
          PK_EVT:  plen = {8'h00, hdr_bytes[1]};
          PK_ACL:  plen = {hdr_bytes[3], hdr_bytes[2]};
          default: plen = {hdr_bytes[3], hdr_bytes[2]} & ISO_LEN_MASK;
        endcase
        if (!grant) begin
          add_word(8'h00, st_code, STAT_NOBUF, 1'b0);
          go_idle();
        end else begin
          for (int i = 0; i < hlen; i++)
            add_word(hdr_bytes[i], st_code, STAT_BYTE, (plen == 0) && (i == hlen - 1));
          if (plen == 0) go_idle();
          else begin
            st_hdr_done = 1'b1;
            st_left     = plen;
          end
        end
      end
    end else begin
      st_left = st_left - 16'd1;
      add_word(b, st_code, STAT_BYTE, st_left == 0);
      if (st_left == 0) go_idle();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic g);
    rx_item_t it;
    it.b     = b;
    it.grant = g;
    rx_q.push_back(it);
  endtask

  // Queue a type byte, its header and, when granted, npay payload bytes.
  // buffer_granted is random on every byte but the one that completes the header.
  task automatic queue_packet(input logic [7:0] ptype, input logic [7:0] h0, input logic [7:0] h1,
                              input logic [7:0] h2, input logic [7:0] h3,
                              input logic grant, input int npay);
    logic [7:0] hb [4];
    int         hlen;
    hb[0] = h0; hb[1] = h1; hb[2] = h2; hb[3] = h3;
    hlen  = (ptype == TYPE_EVT) ? 2 : 4;
    queue_byte(ptype, 1'($urandom_range(0, 1)));
    for (int i = 0; i < hlen; i++)
      queue_byte(hb[i], (i == hlen - 1) ? grant : 1'($urandom_range(0, 1)));
    if (grant)
      for (int i = 0; i < npay; i++)
        queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Driver: offer the next byte once the previous one is taken and its gap has run out.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && item_ready) begin
        deframe_byte(rx_byte, buffer_granted);
        bytes_taken <= bytes_taken + 1;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 7);
      end
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          item_valid <= 1'b0;
          send_gap--;
        end else if (rx_q.size() != 0) begin
          next_item = rx_q.pop_front();
          item_valid     <= 1'b1;
          rx_byte        <= next_item.b;
          buffer_granted <= next_item.grant;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: let the result buffer fill so the input side stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted word against the oldest expected one.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected word, out_byte", int'(out_byte), 0);
        end else begin
          res_t want;
          want = frame_q.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_byte), int'(want.out_byte));
          if (packet_kind !== want.packet_kind)
            report_mismatch("packet_kind", int'(packet_kind), int'(want.packet_kind));
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (last !== want.last)
            report_mismatch("last", int'(last), int'(want.last));
        end
        words_seen++;
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 7);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      result_ready <= (recv_stall == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, frame_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim
    logic [15:0] plen;
    logic [7:0]  nb;
    logic        grant;

    // Directed: unknown type extremes, zero-length and dropped packets, ISO length mask.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_packet(TYPE_EVT, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 0);
    queue_packet(TYPE_EVT, 8'h0E, 8'h05, 8'h00, 8'h00, 1'b0, 0);
    queue_packet(TYPE_EVT, 8'h0E, 8'h02, 8'h00, 8'h00, 1'b1, 2);
    queue_packet(TYPE_ACL, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 0);
    queue_packet(TYPE_ISO, 8'h00, 8'h00, 8'h01, 8'hC0, 1'b1, 1);
    queue_packet(TYPE_ISO, 8'h12, 8'h34, 8'h00, 8'hC0, 1'b1, 0);

    // Random: mostly well-formed packets with random content, some stray bytes.
    while (rx_q.size() < 300) begin
      if ($urandom_range(0, 9) == 0) begin
        do nb = 8'($urandom_range(0, 255));
        while (nb == TYPE_EVT || nb == TYPE_ACL || nb == TYPE_ISO);
        queue_byte(nb, 1'($urandom_range(0, 1)));
      end else begin
        plen  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(7, 40))
                                             : 16'($urandom_range(0, 6));
        grant = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: queue_packet(TYPE_EVT, 8'($urandom_range(0, 255)), plen[7:0], 8'h00, 8'h00,
                          grant, int'(plen));
          1: queue_packet(TYPE_ACL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          plen[7:0], plen[15:8], grant, int'(plen));
          default: queue_packet(TYPE_ISO, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), plen[7:0],
                                {2'($urandom_range(0, 3)), plen[13:8]}, grant, int'(plen));
        endcase
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last byte to be taken, then for every expected word.
    while (rx_q.size() != 0 || item_valid) @(negedge clk);
    while (frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);

    if (frame_q.size() != 0) report_mismatch("words left over", frame_q.size(), 0);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
